/* sv/izs_pkg.sv */
// Shared types, constants and helpers for the irrigation zone sequencer.
package izs_pkg;

   localparam int ZONES     = 8;
   localparam int ZONE_W    = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int ZIDX_W    = $clog2(ZONES + 1);
   localparam int MASK_W    = (ZONES > 8) ? ZONES : 8;
   localparam int TICK_W    = 24;
   localparam int MIN_W     = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [TICK_W-1:0] ON_SETTLE_RST  = TICK_W'(300);
   localparam logic [TICK_W-1:0] OFF_SETTLE_RST = TICK_W'(300);
   localparam logic [TICK_W-1:0] TPM_RST        = TICK_W'(6000);

   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_PRESS   = 3'd1,
      ACT_START   = 3'd2,
      ACT_STOP    = 3'd3,
      ACT_RESTART = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      PH_FINISHED   = 3'd0,
      PH_UI         = 3'd1,
      PH_SETTLE_ON  = 3'd2,
      PH_ON         = 3'd3,
      PH_SETTLE_OFF = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_SETTLE     = 2'd0,
      CSR_OFF_SETTLE    = 2'd1,
      CSR_TICKS_PER_MIN = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PRESS,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [TICK_W-1:0] on_settle;
      logic [TICK_W-1:0] off_settle;
      logic [TICK_W-1:0] ticks_per_min;
   } cfg_type;

   typedef struct packed {
      phase_type        phase;
      logic             zone_valid;
      logic [2:0]       current_zone;
      logic [MIN_W-1:0] zone_minutes;
      logic [MIN_W-1:0] remaining_minutes;
      logic [7:0]       relay_mask;
      logic             modified;
      logic             running;
   } rsp_type;

   // time ladder 1,2,3,4,5,7,10,13,16,20,25,30,0
   function automatic logic [MIN_W-1:0] next_time(input logic [MIN_W-1:0] v);
      logic [MIN_W-1:0] r;
      if (v < MIN_W'(5))       r = v + MIN_W'(1);
      else if (v < MIN_W'(7))  r = v + MIN_W'(2);
      else if (v < MIN_W'(16)) r = v + MIN_W'(3);
      else if (v < MIN_W'(20)) r = v + MIN_W'(4);
      else if (v < MIN_W'(30)) r = v + MIN_W'(5);
      else                     r = '0;
      return r;
   endfunction

endpackage

/* sv/izs_ram.sv */
// Generic single-port-write, registered-read RAM.
module izs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/izs_csr.sv */
// Configuration registers: settle delays and minute length.
module izs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [izs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [izs_pkg::TICK_W-1:0]       csr_wdata,
   output izs_pkg::cfg_type                 cfg
);
   import izs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ON_SETTLE:     cfg_in.on_settle     = csr_wdata;
            CSR_OFF_SETTLE:    cfg_in.off_settle    = csr_wdata;
            CSR_TICKS_PER_MIN: cfg_in.ticks_per_min = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_settle     <= ON_SETTLE_RST;
         cfg_ff.off_settle    <= OFF_SETTLE_RST;
         cfg_ff.ticks_per_min <= TPM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/izs_seq.sv */
// Event sequencer: zone selection, run phases and minutes-table read-modify-write.
module izs_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_action,
   input  logic [2:0]                     req_zone,
   input  izs_pkg::cfg_type               cfg,
   output logic                           ram_wr_en,
   output logic [izs_pkg::ZONE_W-1:0]     ram_wr_addr,
   output logic [izs_pkg::MIN_W-1:0]      ram_wr_data,
   output logic [izs_pkg::ZONE_W-1:0]     ram_rd_addr,
   input  logic [izs_pkg::MIN_W-1:0]      ram_rd_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output izs_pkg::rsp_type               rsp
);
   import izs_pkg::*;

   state_type         state_ff, state_in;
   logic [2:0]        act_ff, act_in;
   logic [2:0]        zin_ff, zin_in;
   phase_type         phase_ff, phase_in;
   logic              zsel_ff, zsel_in;
   logic [ZONE_W-1:0] zone_ff, zone_in;
   logic              edited_ff, edited_in;
   logic [ZONES-1:0]  relay_ff, relay_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [MIN_W-1:0]  min_ff, min_in;
   logic [MIN_W-1:0]  cur_ff, cur_in;     // copy of the table entry of the selected zone
   logic [ZONES-1:0]  wv_ff, wv_in;       // entry written since reset
   logic [ZIDX_W-1:0] idx_ff, idx_in;
   logic              restart_ff, restart_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              zin_ok;
   logic [ZONE_W-1:0] zin_z;
   logic [ZONE_W-1:0] pick;
   logic [TICK_W-1:0] tpm_eff;
   logic [TICK_W-1:0] tick_sat;
   logic [TICK_W:0]   on_t25;
   logic              on_roll;
   logic [TICK_W-1:0] on_tick;
   logic [MIN_W-1:0]  on_min;
   logic              on_end;
   logic [ZIDX_W-1:0] seek_start;
   logic [ZIDX_W-1:0] idx_next;
   logic [MIN_W-1:0]  scan_val;
   logic [MIN_W-1:0]  press_val;
   logic [MIN_W-1:0]  nt_val;
   logic [MIN_W-1:0]  out_mins;
   logic [MIN_W-1:0]  out_rem;
   logic [MASK_W-1:0] relay_wide;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign zin_ok     = (int'(zin_ff) < ZONES);
   assign zin_z      = ZONE_W'(zin_ff);
   assign pick       = zin_ok ? zin_z : '0;
   assign tpm_eff    = (cfg.ticks_per_min == '0) ? TICK_W'(1) : cfg.ticks_per_min;
   assign tick_sat   = (&tick_ff) ? tick_ff : tick_ff + TICK_W'(1);

   // on phase: advance tick, roll into minutes, check for end of watering
   assign on_t25  = {1'b0, tick_ff} + (TICK_W+1)'(1);
   assign on_roll = (on_t25 >= {1'b0, tpm_eff});
   assign on_tick = on_roll ? '0 : on_t25[TICK_W-1:0];
   assign on_min  = (on_roll && !(&min_ff)) ? min_ff + MIN_W'(1) : min_ff;
   assign on_end  = (on_min > cur_ff) || ((on_min == cur_ff) && (on_tick != '0));

   assign seek_start = ZIDX_W'(zone_ff) + ZIDX_W'(1);
   assign idx_next   = idx_ff + ZIDX_W'(1);
   assign scan_val   = wv_ff[idx_ff[ZONE_W-1:0]] ? ram_rd_data : '0;
   assign press_val  = wv_ff[zone_ff] ? ram_rd_data : '0;
   assign nt_val     = next_time(cur_ff);

   assign out_mins   = zsel_ff ? cur_ff : '0;
   assign out_rem    = (phase_ff != PH_ON) ? out_mins :
                       (min_ff < out_mins) ? out_mins - min_ff : '0;
   assign relay_wide = MASK_W'(relay_ff);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      zin_in       = zin_ff;
      phase_in     = phase_ff;
      zsel_in      = zsel_ff;
      zone_in      = zone_ff;
      edited_in    = edited_ff;
      relay_in     = relay_ff;
      tick_in      = tick_ff;
      min_in       = min_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      restart_in   = restart_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = zone_ff;
      ram_wr_data  = '0;
      ram_rd_addr  = zone_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = req_action;
               zin_in   = req_zone;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_DONE;
            case (act_ff)
               ACT_TICK: begin
                  if (zsel_ff) begin
                     case (phase_ff)
                        PH_SETTLE_ON: begin
                           if (tick_sat > cfg.on_settle) begin
                              relay_in[zone_ff] = 1'b1;
                              tick_in           = '0;
                              min_in            = '0;
                              phase_in          = PH_ON;
                           end else begin
                              tick_in = tick_sat;
                           end
                        end
                        PH_ON: begin
                           tick_in = on_tick;
                           min_in  = on_min;
                           if (on_end) begin
                              relay_in[zone_ff] = 1'b0;
                              ram_wr_en         = 1'b1;
                              ram_wr_data       = '0;
                              cur_in            = '0;
                              tick_in           = '0;
                              min_in            = '0;
                              phase_in          = PH_SETTLE_OFF;
                           end
                        end
                        PH_SETTLE_OFF: begin
                           if (tick_sat > cfg.off_settle) begin
                              tick_in = '0;
                              min_in  = '0;
                              if (seek_start == ZIDX_W'(ZONES)) begin
                                 phase_in = PH_FINISHED;
                                 zsel_in  = 1'b0;
                                 zone_in  = '0;
                              end else begin
                                 idx_in      = seek_start;
                                 ram_rd_addr = seek_start[ZONE_W-1:0];
                                 restart_in  = 1'b0;
                                 state_in    = ST_SCAN;
                              end
                           end else begin
                              tick_in = tick_sat;
                           end
                        end
                        default: ;
                     endcase
                  end
               end

               ACT_PRESS: begin
                  if (zin_ok) begin
                     phase_in = PH_UI;
                     tick_in  = '0;
                     min_in   = '0;
                     if (!zsel_ff || (zone_ff != zin_z)) begin
                        zone_in     = zin_z;
                        zsel_in     = 1'b1;
                        ram_rd_addr = zin_z;
                        state_in    = ST_PRESS;
                     end else begin
                        edited_in   = 1'b1;
                        ram_wr_en   = 1'b1;
                        ram_wr_data = nt_val;
                        cur_in      = nt_val;
                     end
                  end
               end

               ACT_START, ACT_RESTART: begin
                  tick_in     = '0;
                  min_in      = '0;
                  idx_in      = '0;
                  ram_rd_addr = '0;
                  restart_in  = (act_ff == ACT_RESTART);
                  state_in    = ST_SCAN;
               end

               ACT_STOP: begin
                  phase_in = PH_FINISHED;
                  zsel_in  = 1'b0;
                  zone_in  = '0;
                  tick_in  = '0;
                  min_in   = '0;
               end

               default: ;
            endcase
         end

         ST_PRESS: begin
            // newly selected zone: an empty time becomes one minute
            if (press_val == '0) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = MIN_W'(1);
               edited_in   = 1'b1;
               cur_in      = MIN_W'(1);
            end else begin
               cur_in = press_val;
            end
            state_in = ST_DONE;
         end

         ST_SCAN: begin
            ram_rd_addr = idx_next[ZONE_W-1:0];
            if (scan_val != '0) begin
               zone_in = idx_ff[ZONE_W-1:0];
               zsel_in = 1'b1;
               cur_in  = scan_val;
               if (restart_ff) begin
                  phase_in  = PH_UI;
                  edited_in = 1'b0;
                  relay_in  = '0;
               end else begin
                  phase_in = PH_SETTLE_ON;
               end
               state_in = ST_DONE;
            end else if (idx_ff == ZIDX_W'(ZONES - 1)) begin
               if (restart_ff) begin
                  // nothing programmed: take the given zone (zone 0 if out of range) with one minute
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pick;
                  ram_wr_data = MIN_W'(1);
                  zone_in     = pick;
                  zsel_in     = 1'b1;
                  cur_in      = MIN_W'(1);
                  edited_in   = 1'b0;
                  relay_in    = '0;
                  phase_in    = PH_UI;
               end else begin
                  phase_in = PH_FINISHED;
                  zsel_in  = 1'b0;
                  zone_in  = '0;
               end
               state_in = ST_DONE;
            end else begin
               idx_in = idx_next;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_in.phase             = phase_ff;
               rsp_in.zone_valid        = zsel_ff;
               rsp_in.current_zone      = zsel_ff ? 3'(zone_ff) : 3'd0;
               rsp_in.zone_minutes      = out_mins;
               rsp_in.remaining_minutes = zsel_ff ? out_rem : '0;
               rsp_in.relay_mask        = relay_wide[7:0];
               rsp_in.modified          = edited_ff;
               rsp_in.running           = (phase_ff != PH_FINISHED);
               state_in                 = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      wv_in = wv_ff;
      if (ram_wr_en) begin
         wv_in[ram_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FINISHED;
         zsel_ff      <= 1'b0;
         zone_ff      <= '0;
         edited_ff    <= 1'b0;
         relay_ff     <= '0;
         tick_ff      <= '0;
         min_ff       <= '0;
         wv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         zsel_ff      <= zsel_in;
         zone_ff      <= zone_in;
         edited_ff    <= edited_in;
         relay_ff     <= relay_in;
         tick_ff      <= tick_in;
         min_ff       <= min_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      zin_ff     <= zin_in;
      cur_ff     <= cur_in;
      idx_ff     <= idx_in;
      restart_ff <= restart_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* sv/irrigation_zone_sequencer.sv */
// Irrigation zone sequencer top level.
// A transfer enters the execute state; the done state registers the result once the
// output is not stalled. A press on a new zone adds the press state; start, restart
// and zone advance add one scan step per minutes-table entry (up to ZONES), one RAM
// read per cycle. One item at a time: the next transfer is taken the cycle after the
// result is registered. Reset is synchronous and clears control state, not data regs.
module irrigation_zone_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_action,
   input  logic [2:0]                    req_zone,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_phase,
   output logic                          rsp_zone_valid,
   output logic [2:0]                    rsp_current_zone,
   output logic [4:0]                    rsp_zone_minutes,
   output logic [4:0]                    rsp_remaining_minutes,
   output logic [7:0]                    rsp_relay_mask,
   output logic                          rsp_modified,
   output logic                          rsp_running,
   input  logic                          csr_we,
   input  logic [izs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [izs_pkg::TICK_W-1:0]    csr_wdata
);
   import izs_pkg::*;

   cfg_type           cfg;
   rsp_type           rsp;
   logic              ram_wr_en;
   logic [ZONE_W-1:0] ram_wr_addr;
   logic [MIN_W-1:0]  ram_wr_data;
   logic [ZONE_W-1:0] ram_rd_addr;
   logic [MIN_W-1:0]  ram_rd_data;

   izs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   izs_ram #(
      .WIDTH  (MIN_W),
      .DEPTH  (ZONES),
      .ADDR_W (ZONE_W)
   ) u_minutes_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   izs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_zone    (req_zone),
      .cfg         (cfg),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   assign rsp_phase             = rsp.phase;
   assign rsp_zone_valid        = rsp.zone_valid;
   assign rsp_current_zone      = rsp.current_zone;
   assign rsp_zone_minutes      = rsp.zone_minutes;
   assign rsp_remaining_minutes = rsp.remaining_minutes;
   assign rsp_relay_mask        = rsp.relay_mask;
   assign rsp_modified          = rsp.modified;
   assign rsp_running           = rsp.running;

endmodule

/* sv/izs_checker.sv */
// Port-level checks for the irrigation zone sequencer, bound to the top level.
module izs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [2:0]                    req_action,
   input logic [2:0]                    req_zone,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [2:0]                    rsp_phase,
   input logic                          rsp_zone_valid,
   input logic [2:0]                    rsp_current_zone,
   input logic [4:0]                    rsp_zone_minutes,
   input logic [4:0]                    rsp_remaining_minutes,
   input logic [7:0]                    rsp_relay_mask,
   input logic                          rsp_modified,
   input logic                          rsp_running,
   input logic                          csr_we,
   input logic [izs_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [izs_pkg::TICK_W-1:0]    csr_wdata
);
   import izs_pkg::*;

   // one item in flight: a transfer closes the input side on the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after a transfer");

   // a selected zone exists exactly while a phase other than finished is shown
   a_zone_vs_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zone_valid == rsp_running))
      else $error("zone_valid disagrees with running");

   a_no_zone_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_zone_valid) |->
         (rsp_current_zone == 3'd0 && rsp_zone_minutes == 5'd0 &&
          rsp_remaining_minutes == 5'd0))
      else $error("fields not cleared without a zone");

   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_remaining_minutes <= rsp_zone_minutes))
      else $error("remaining minutes exceed programmed minutes");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_phase) && $stable(rsp_relay_mask) &&
          $stable(rsp_remaining_minutes) && $stable(rsp_current_zone)))
      else $error("stalled result changed");

endmodule

bind irrigation_zone_sequencer izs_checker u_izs_checker (.*);
